[design/ssba_pkg.sv]
// Shared types and constants of the spectrum slot bitmap allocator.
// Holds request and status codes, and the structs passed between the modules.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package ssba_pkg;

  // Field widths of the request, result and capacity register.
  localparam int KIND_W   = 2;
  localparam int FIRST_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;
  localparam int STATUS_W = 2;
  localparam int MAP_W    = 64;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD      = 2'd3;

  // Command from the controller that starts one walk over the slots.
  typedef struct packed {
    logic                start;
    logic [KIND_W-1:0]   kind;
    logic [FIRST_W-1:0]  first;
    logic [COUNT_W-1:0]  stop;
    logic [COUNT_W-1:0]  count;
    logic [CAP_W-1:0]    limit;
  } walk_ctrl_t;

  // Status of the walker back to the controller.
  typedef struct packed {
    logic busy;
    logic done;
    logic conflict;
    logic any;
  } walk_stat_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAP_W-1:0]    start_map;
    logic                any_start;
  } result_t;

endpackage

`default_nettype wire

[design/ssba_in_if.sv]
// Request channel of the slot bitmap allocator: valid, ready and the request fields.
// Depends on ssba_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssba_in_if;
  import ssba_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [FIRST_W-1:0]  first_slot;
  logic [COUNT_W-1:0]  slot_count;

  modport source (output valid, output kind, output first_slot, output slot_count,
                  input ready);
  modport sink   (input valid, input kind, input first_slot, input slot_count,
                  output ready);
endinterface

`default_nettype wire

[design/ssba_out_if.sv]
// Result channel of the slot bitmap allocator: valid, ready and the result fields.
// Depends on ssba_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssba_out_if;
  import ssba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [MAP_W-1:0]    start_map;
  logic                any_start;

  modport source (output valid, output status, output start_map, output any_start,
                  input ready);
  modport sink   (input valid, input status, input start_map, input any_start,
                  output ready);
endinterface

`default_nettype wire

[design/ssba_cfg_if.sv]
// Configuration write channel of the slot bitmap allocator: the link capacity.
// Depends on ssba_pkg for the register width.
`timescale 1ns / 1ps
`default_nettype none

interface ssba_cfg_if;
  import ssba_pkg::*;

  logic               valid;
  logic               ready;
  logic [CAP_W-1:0]   link_capacity;

  modport source (output valid, output link_capacity, input ready);
  modport sink   (input valid, input link_capacity, output ready);
endinterface

`default_nettype wire

[design/ssba_walker.sv]
// Bit-serial slot walker: occupancy rotate register, shadow map and start-map shifter.
// Visits one slot per cycle from the highest down to slot 0. Depends on ssba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssba_walker #(
  parameter int SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssba_pkg::walk_ctrl_t  ctrl,
  output ssba_pkg::walk_stat_t  stat,
  output logic [SLOTS-1:0]      start_bits
);
  import ssba_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [SLOTS-1:0]    occ_r, occ_nxt;
  logic [SLOTS-1:0]    new_r, new_nxt;
  logic [SLOTS-1:0]    stmap_r, stmap_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                busy_r, busy_nxt;
  logic                conf_r, conf_nxt;
  logic                any_r, any_nxt;
  logic [COUNT_W-1:0]  run_r, run_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [FIRST_W-1:0]  first_r, first_nxt;
  logic [COUNT_W-1:0]  stop_r, stop_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]    limit_r, limit_nxt;

  logic                slot_bit;
  logic [COUNT_W-1:0]  idx_w;
  logic                in_run;
  logic                is_query;
  logic                is_reserve;
  logic [COUNT_W-1:0]  run_cur;
  logic                hit;
  logic                conf_now;
  logic                new_bit;
  logic                last;

  // Per-slot evaluation of the bit that sits at the top of the rotate register.
  always_comb begin
    slot_bit   = occ_r[SLOTS-1];
    idx_w      = COUNT_W'(idx_r);
    in_run     = (idx_w >= {1'b0, first_r}) && (idx_w < stop_r);
    is_query   = (kind_r == KIND_QUERY);
    is_reserve = (kind_r == KIND_RESERVE);
    // Length of the free run that starts at this slot and goes upward.
    run_cur    = slot_bit ? '0 : run_r + 1'b1;
    hit        = is_query && !slot_bit && (run_cur >= count_r) && (idx_w <= limit_r);
    conf_now   = !is_query && in_run && (is_reserve ? slot_bit : !slot_bit);
    new_bit    = (!is_query && in_run) ? is_reserve : slot_bit;
    last       = (idx_r == '0);
  end

  // Walk sequencing and commit of the shadow map on the last slot.
  always_comb begin
    occ_nxt   = occ_r;
    new_nxt   = new_r;
    stmap_nxt = stmap_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    conf_nxt  = conf_r;
    any_nxt   = any_r;
    run_nxt   = run_r;
    kind_nxt  = kind_r;
    first_nxt = first_r;
    stop_nxt  = stop_r;
    count_nxt = count_r;
    limit_nxt = limit_r;
    if (ctrl.start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = LAST_IDX;
      conf_nxt  = 1'b0;
      any_nxt   = 1'b0;
      run_nxt   = '0;
      stmap_nxt = '0;
      kind_nxt  = ctrl.kind;
      first_nxt = ctrl.first;
      stop_nxt  = ctrl.stop;
      count_nxt = ctrl.count;
      limit_nxt = ctrl.limit;
    end else if (busy_r) begin
      occ_nxt   = {occ_r[SLOTS-2:0], occ_r[SLOTS-1]};
      new_nxt   = {new_r[SLOTS-2:0], new_bit};
      stmap_nxt = {stmap_r[SLOTS-2:0], hit};
      any_nxt   = any_r | hit;
      conf_nxt  = conf_r | conf_now;
      run_nxt   = run_cur;
      idx_nxt   = idx_r - 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        // The map is only changed when the whole run was clean.
        if (!is_query && !(conf_r || conf_now)) begin
          occ_nxt = {new_r[SLOTS-2:0], new_bit};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      busy_r <= 1'b0;
      conf_r <= 1'b0;
      any_r  <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      busy_r <= busy_nxt;
      conf_r <= conf_nxt;
      any_r  <= any_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    new_r   <= new_nxt;
    stmap_r <= stmap_nxt;
    idx_r   <= idx_nxt;
    run_r   <= run_nxt;
    kind_r  <= kind_nxt;
    first_r <= first_nxt;
    stop_r  <= stop_nxt;
    count_r <= count_nxt;
    limit_r <= limit_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = busy_r && last;
  assign stat.conflict = conf_r;
  assign stat.any      = any_r;
  assign start_bits    = stmap_r;

`ifndef ASSERT_OFF
  // A new walk is only started while no walk is running.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !busy_r)
    else $error("walk started while busy");

  // A query never changes the occupancy map.
  a_query_keeps_map: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && is_query && last) |=> (occ_r == $past(occ_r, SLOTS)))
    else $error("query changed the occupancy map");

  // A conflict found before the last slot means the map is left unchanged.
  a_conflict_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && last && conf_r) |=> (occ_r == $past(occ_r, SLOTS)))
    else $error("map changed after a conflict");
`endif

endmodule

`default_nettype wire

[design/ssba_out_reg.sv]
// Output register of the slot bitmap allocator: holds one result until it is taken.
// Depends on ssba_pkg and the ssba_out_if interface.
`timescale 1ns / 1ps
`default_nettype none

module ssba_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ssba_pkg::result_t  res,
  output logic               free,
  ssba_out_if.source         out_ch
);
  import ssba_pkg::*;

  logic     valid_r, valid_nxt;
  result_t  res_r, res_nxt;

  // The register can take a new result when empty or when its content leaves now.
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load && free) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.status    = res_r.status;
  assign out_ch.start_map = res_r.start_map;
  assign out_ch.any_start = res_r.any_start;

endmodule

`default_nettype wire

[design/spectrum_slot_bitmap_allocator.sv]
// Top level of the spectrum slot bitmap allocator: request checks, control and config.
// Depends on ssba_pkg, the three channel interfaces, ssba_walker and ssba_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Keeps one occupancy bit per frequency slot and serves one request at a time:
// reserve a run, free a run, or query every start of a free run of a given length.
// Requests that fail a range or sanity check (run past the capacity, empty run,
// bad query count, unknown kind) pass from the result state into the output
// register without a walk and without touching the map. Every other request walks
// the occupancy shift register one slot per cycle over all SLOTS bits in a
// bit-serial scan, then passes through the result state into the output register.
// A loaded result can be taken in the cycle after it is loaded, at the earliest.
// The next request is accepted as soon as the previous result has moved into the
// output register, even if that result is not yet taken.
// The capacity register may be written at any time the block is idle.
module spectrum_slot_bitmap_allocator #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ssba_in_if.sink     in_ch,
  ssba_cfg_if.sink    cfg_ch,
  ssba_out_if.source  out_ch
);
  import ssba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(SLOTS);

  state_t                state_r, state_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic                  direct_r, direct_nxt;
  logic [STATUS_W-1:0]   dstat_r, dstat_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;

  logic [CAP_W-1:0]      cap_eff;
  logic                  accept;
  logic [COUNT_W:0]      run_end;
  logic                  pre_direct;
  logic [STATUS_W-1:0]   pre_status;
  walk_ctrl_t            wk_ctrl;
  walk_stat_t            wk_stat;
  logic [SLOTS-1:0]      start_bits;
  result_t               res;
  logic                  out_free;

  // Capacity register; out-of-range settings are clamped to 1..SLOTS.
  assign cfg_ch.ready = 1'b1;
  assign cap_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.link_capacity : cap_r;
  assign cap_eff = (cap_r == '0) ? CAP_W'(1) : ((cap_r > CAP_MAX) ? CAP_MAX : cap_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign run_end     = {2'b00, in_ch.first_slot} + {1'b0, in_ch.slot_count};

  // Checks that answer a request without a walk.
  always_comb begin
    pre_direct = 1'b0;
    pre_status = STAT_OK;
    case (in_ch.kind)
      KIND_RESERVE, KIND_FREE: begin
        if (run_end > {1'b0, cap_eff}) begin
          pre_direct = 1'b1;
          pre_status = STAT_RANGE;
        end else if (in_ch.slot_count == '0) begin
          pre_direct = 1'b1;
        end
      end
      KIND_QUERY: begin
        if ((in_ch.slot_count == '0) || (in_ch.slot_count >= cap_eff)) begin
          pre_direct = 1'b1;
          pre_status = STAT_BAD;
        end
      end
      default: begin
        pre_direct = 1'b1;
        pre_status = STAT_BAD;
      end
    endcase
  end

  // Walk command: run bounds for reserve and free, last legal start for a query.
  always_comb begin
    wk_ctrl.start = accept && !pre_direct;
    wk_ctrl.kind  = in_ch.kind;
    wk_ctrl.first = in_ch.first_slot;
    wk_ctrl.stop  = run_end[COUNT_W-1:0];
    wk_ctrl.count = in_ch.slot_count;
    wk_ctrl.limit = cap_eff - in_ch.slot_count;
  end

  // Controller state machine.
  always_comb begin
    state_nxt  = state_r;
    direct_nxt = direct_r;
    dstat_nxt  = dstat_r;
    kind_nxt   = kind_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          direct_nxt = pre_direct;
          dstat_nxt  = pre_status;
          kind_nxt   = in_ch.kind;
          state_nxt  = pre_direct ? S_FIN : S_WALK;
        end
      end
      S_WALK: begin
        if (wk_stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= CAP_W'(64);
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    direct_r <= direct_nxt;
    dstat_r  <= dstat_nxt;
    kind_r   <= kind_nxt;
  end

  // Result assembly from the check outcome or the walker's final registers.
  always_comb begin
    res.start_map = '0;
    res.any_start = 1'b0;
    if (direct_r) begin
      res.status = dstat_r;
    end else if (kind_r == KIND_QUERY) begin
      res.status                 = STAT_OK;
      res.start_map[SLOTS-1:0]   = start_bits;
      res.any_start              = wk_stat.any;
    end else begin
      res.status = wk_stat.conflict ? STAT_CONFLICT : STAT_OK;
    end
  end

  ssba_walker #(
    .SLOTS (SLOTS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (wk_ctrl),
    .stat       (wk_stat),
    .start_bits (start_bits)
  );

  ssba_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (state_r == S_FIN),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // The walker only finishes while the controller waits for it.
  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wk_stat.done |-> (state_r == S_WALK))
    else $error("walk finished outside the walk state");

  // A finished walk is handed to the result stage on the next cycle.
  a_done_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wk_stat.done |=> (state_r == S_FIN))
    else $error("finished walk not followed by result stage");

  // Any result other than ok carries an empty start map.
  a_err_empty_map: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STAT_OK)) |->
      ((out_ch.start_map == '0) && !out_ch.any_start))
    else $error("error result with a start map");

  // The any flag agrees with the start map.
  a_any_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.any_start == (out_ch.start_map != '0)))
    else $error("any_start disagrees with start_map");
`endif

endmodule

`default_nettype wire

[test/spectrum_slot_bitmap_allocator_tb.sv]
// Self-checking testbench for the spectrum slot bitmap allocator.
// Needs ssba_pkg, the three channel interfaces and the allocator top level.
// Runs directed and random requests under several link capacities.
`timescale 1ns / 1ps

module spectrum_slot_bitmap_allocator_tb;
  import ssba_pkg::*;

  localparam int SLOTS = 64;
  localparam int MAX_SHOWN = 10;
  localparam int DRAIN_LIMIT = 200000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One pending request transaction, with the idle cycles to leave before it.
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [FIRST_W-1:0] slot_first;
    logic [COUNT_W-1:0] slot_count;
    int unsigned        gap;
  } request_t;

  logic clk;
  logic rst_n;

  ssba_in_if  in_ch();
  ssba_out_if out_ch();
  ssba_cfg_if cfg_ch();

  spectrum_slot_bitmap_allocator #(
    .SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  request_t         pending_requests[$];
  result_t          expected_results[$];
  logic [MAP_W-1:0] slot_occupancy;
  logic [CAP_W-1:0] capacity_setting;
  bit               idle_on;
  int unsigned      stall_left;
  int unsigned      failures;
  int unsigned      results_checked;
  int unsigned      capacity_writes;
  int unsigned      kind_seen[4];

  // Free-running clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mask with the lowest n bits set.
  function automatic logic [MAP_W-1:0] low_ones(input int unsigned n);
    if (n >= MAP_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Capacity as the block uses it: clamped to 1..SLOTS.
  function automatic int unsigned effective_capacity();
    if (capacity_setting == 0) return 1;
    if (capacity_setting > SLOTS) return SLOTS;
    return capacity_setting;
  endfunction

  // Idle cycles: mostly none, sometimes a few, rarely a long stretch.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_SHOWN) $display("ERROR: %s", msg);
  endtask

  // Applies one accepted request to the occupancy map and records its result.
  task automatic apply_request(input logic [KIND_W-1:0] kind,
                               input logic [FIRST_W-1:0] slot_first,
                               input logic [COUNT_W-1:0] slot_count);
    int unsigned      cap;
    int unsigned      fst;
    int unsigned      cnt;
    logic [MAP_W-1:0] run;
    logic [MAP_W-1:0] free_slots;
    logic [MAP_W-1:0] starts;
    result_t          res;
    cap = effective_capacity();
    fst = slot_first;
    cnt = slot_count;
    res = '0;
    res.status = STAT_OK;
    kind_seen[kind]++;
    case (kind)
      KIND_RESERVE, KIND_FREE: begin
        if (fst + cnt > cap) begin
          res.status = STAT_RANGE;
        end else if (cnt != 0) begin
          run = low_ones(cnt) << fst;
          if (kind == KIND_RESERVE) begin
            if ((slot_occupancy & run) != '0) res.status = STAT_CONFLICT;
            else slot_occupancy = slot_occupancy | run;
          end else begin
            if ((slot_occupancy & run) != run) res.status = STAT_CONFLICT;
            else slot_occupancy = slot_occupancy & ~run;
          end
        end
      end
      KIND_QUERY: begin
        if (cnt == 0 || cnt >= cap) begin
          res.status = STAT_BAD;
        end else begin
          free_slots = ~slot_occupancy;
          starts = free_slots;
          for (int k = 1; k < cnt; k++) starts = starts & (free_slots >> k);
          res.start_map = starts & low_ones(cap - cnt + 1);
          res.any_start = |res.start_map;
        end
      end
      default: begin
        res.status = STAT_BAD;
      end
    endcase
    expected_results.insert(expected_results.size(), res);
  endtask

  // Puts the oldest pending request on the input channel.
  task automatic present_next();
    request_t req;
    req = pending_requests.pop_front();
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= req.kind;
    in_ch.first_slot <= req.slot_first;
    in_ch.slot_count <= req.slot_count;
  endtask

  // Request driver: accepted transactions feed the prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      apply_request(in_ch.kind, in_ch.first_slot, in_ch.slot_count);
      if (pending_requests.size() != 0 && pending_requests[0].gap == 0) present_next();
      else in_ch.valid <= 1'b0;
    end else if (!in_ch.valid && pending_requests.size() != 0) begin
      if (pending_requests[0].gap != 0) pending_requests[0].gap = pending_requests[0].gap - 1;
      else present_next();
    end
  end

  // Result monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_t     want;
    int unsigned gap;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d map %h any %0b",
                                 out_ch.status, out_ch.start_map, out_ch.any_start));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_ch.status !== want.status || out_ch.start_map !== want.start_map ||
              out_ch.any_start !== want.any_start) begin
            note_failure($sformatf(
              "result %0d: expected status %0d map %h any %0b, got status %0d map %h any %0b",
              results_checked, want.status, want.start_map, want.any_start,
              out_ch.status, out_ch.start_map, out_ch.any_start));
          end
        end
      end
      // Random back-pressure on the result channel.
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          stall_left = gap - 1;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic queue_request(input logic [KIND_W-1:0] kind,
                               input logic [FIRST_W-1:0] slot_first,
                               input logic [COUNT_W-1:0] slot_count);
    request_t req;
    req.kind = kind;
    req.slot_first = slot_first;
    req.slot_count = slot_count;
    req.gap = idle_gap();
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Waits until every request has been answered, then lets the block settle.
  task automatic wait_idle();
    int unsigned spent;
    spent = 0;
    while ((pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0) &&
           spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
    end
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  // Writes the link capacity once the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.link_capacity <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    capacity_setting = value;
    capacity_writes++;
  endtask

  // Random requests: mostly runs that fit, frees of earlier runs and queries,
  // with some fully random noise mixed in.
  task automatic queue_random_requests(input int unsigned n);
    int unsigned cap;
    int unsigned r;
    int unsigned fst;
    int unsigned cnt;
    int unsigned pick;
    int unsigned held_first[$];
    int unsigned held_count[$];
    cap = effective_capacity();
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if ($urandom_range(0, 9) == 0) cnt = $urandom_range(1, cap);
        else cnt = $urandom_range(1, (cap < 8) ? cap : 8);
        fst = $urandom_range(0, cap - cnt);
        held_first.insert(held_first.size(), fst);
        held_count.insert(held_count.size(), cnt);
        queue_request(KIND_RESERVE, FIRST_W'(fst), COUNT_W'(cnt));
      end else if (r < 60) begin
        if (held_first.size() != 0) begin
          pick = $urandom_range(0, held_first.size() - 1);
          fst = held_first[pick];
          cnt = held_count[pick];
          held_first.delete(pick);
          held_count.delete(pick);
        end else begin
          cnt = $urandom_range(1, cap);
          fst = $urandom_range(0, cap - cnt);
        end
        queue_request(KIND_FREE, FIRST_W'(fst), COUNT_W'(cnt));
      end else if (r < 85) begin
        if (cap == 1) cnt = 1;
        else if ($urandom_range(0, 9) == 0) cnt = $urandom_range(1, cap - 1);
        else cnt = $urandom_range(1, (cap - 1 < 8) ? cap - 1 : 8);
        queue_request(KIND_QUERY, FIRST_W'($urandom_range(0, 63)), COUNT_W'(cnt));
      end else begin
        queue_request(KIND_W'($urandom_range(0, 3)), FIRST_W'($urandom_range(0, 63)),
                      COUNT_W'($urandom_range(0, 127)));
      end
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps[10];
    phase_caps = '{7'd64, 7'd1, 7'd16, 7'd127, 7'd40, 7'd0, 7'd64, 7'd9, 7'd64, 7'd23};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_RESERVE;
    in_ch.first_slot = '0;
    in_ch.slot_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.link_capacity = '0;
    out_ch.ready = 1'b0;
    slot_occupancy = '0;
    capacity_setting = 7'd64;
    idle_on = 1'b1;
    failures = 0;
    results_checked = 0;
    capacity_writes = 0;
    stall_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset capacity: query limits, errors,
    // conflicts, empty runs and a completely full link.
    queue_request(KIND_QUERY, 0, 1);
    queue_request(KIND_QUERY, 0, 63);
    queue_request(KIND_QUERY, 63, 64);
    queue_request(KIND_QUERY, 0, 0);
    queue_request(KIND_UNUSED, 63, 127);
    queue_request(KIND_RESERVE, 0, 0);
    queue_request(KIND_RESERVE, 63, 1);
    queue_request(KIND_RESERVE, 63, 2);
    queue_request(KIND_RESERVE, 10, 5);
    queue_request(KIND_RESERVE, 12, 1);
    queue_request(KIND_QUERY, 0, 5);
    queue_request(KIND_FREE, 20, 3);
    queue_request(KIND_FREE, 10, 5);
    queue_request(KIND_FREE, 63, 1);
    queue_request(KIND_RESERVE, 0, 64);
    queue_request(KIND_QUERY, 0, 1);
    queue_request(KIND_FREE, 0, 64);
    queue_request(KIND_FREE, 63, 0);
    queue_request(KIND_RESERVE, 32, 32);

    // Shrunken capacity: slots above it keep their bits but are out of reach.
    write_capacity(7'd8);
    queue_request(KIND_QUERY, 0, 4);
    queue_request(KIND_FREE, 32, 1);

    // A capacity of zero behaves as one slot.
    write_capacity(7'd0);
    queue_request(KIND_QUERY, 0, 1);
    queue_request(KIND_RESERVE, 0, 1);

    // A capacity above the slot count behaves as the full link.
    write_capacity(7'd127);
    queue_request(KIND_FREE, 32, 32);
    queue_request(KIND_FREE, 0, 1);

    // Random phases; every third phase, starting with the second, runs at full rate without idle gaps.
    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      idle_on = (i % 3 != 1);
      queue_random_requests(103);
    end

    wait_idle();
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("Ran %0d reserve, %0d free, %0d query and %0d unknown-kind requests",
             kind_seen[KIND_RESERVE], kind_seen[KIND_FREE], kind_seen[KIND_QUERY],
             kind_seen[KIND_UNUSED]);
    $display("over %0d capacity settings; %0d results checked, %0d failures.",
             capacity_writes, results_checked, failures);
    if (failures == 0) begin
      $display("spectrum_slot_bitmap_allocator_tb passed");
    end else begin
      $display("spectrum_slot_bitmap_allocator_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("spectrum_slot_bitmap_allocator_tb failed");
    $finish;
  end

endmodule
